/* hw/rtl/vmm_pkg.sv */
// ----------------------------------------------------------------------------
// vmm_pkg
// Shared types, widths and helpers of the vector-matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vmm_pkg;

  localparam int IDX_W          = 10;
  localparam int DATA_W         = 32;
  localparam int LEN_W          = 11;
  localparam int MAX_LENGTH_DEF = 1024;
  localparam int RESET_LENGTH   = 1024;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           column;
    logic signed [DATA_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]           result_column;
    logic signed [DATA_W-1:0]   column_sum;
    logic                       final_res;
  } out_item_t;

  // width that holds both the length register and the largest length
  function automatic int cmp_width(input int max_length);
    int lw;
    lw = $clog2(max_length + 1);
    return (lw > LEN_W) ? lw : LEN_W;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vmm_if.sv */
// ----------------------------------------------------------------------------
// vmm_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface vmm_in_if;
  logic               valid;
  logic               ready;
  vmm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vmm_out_if;
  logic               valid;
  logic               ready;
  vmm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vmm_ram.sv */
// ----------------------------------------------------------------------------
// vmm_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module vmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vmm_cfg.sv */
// ----------------------------------------------------------------------------
// vmm_cfg
// Length register: clamps the written length to 1..MAX_LENGTH and keeps the
// index of the last row in use.
// ----------------------------------------------------------------------------
`default_nettype none

module vmm_cfg #(
  parameter int MAX_LENGTH = vmm_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       cfg_we,
  input  wire logic [vmm_pkg::LEN_W-1:0]                  cfg_wdata,
  output logic      [vmm_pkg::cmp_width(MAX_LENGTH)-1:0]  last_row
);

  localparam int CW        = vmm_pkg::cmp_width(MAX_LENGTH);
  localparam int RST_LEN   = (MAX_LENGTH < vmm_pkg::RESET_LENGTH) ?
                             MAX_LENGTH : vmm_pkg::RESET_LENGTH;
  localparam logic [CW-1:0] MAX_V    = CW'(MAX_LENGTH);
  localparam logic [CW-1:0] RST_LAST = CW'(RST_LEN - 1);

  logic [CW-1:0] last_r;
  logic [CW-1:0] last_nxt;
  logic [CW-1:0] wr_ext;
  logic [CW-1:0] len;

  always_comb begin
    wr_ext = CW'(cfg_wdata);
    if (wr_ext == '0) begin
      len = CW'(1);
    end else if (wr_ext > MAX_V) begin
      len = MAX_V;
    end else begin
      len = wr_ext;
    end
    last_nxt = len - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= RST_LAST;
    end else if (cfg_we) begin
      last_r <= last_nxt;
    end
  end

  assign last_row = last_r;

endmodule

`default_nettype wire

/* hw/rtl/vector_matrix_multiply_unit.sv */
// ----------------------------------------------------------------------------
// vector_matrix_multiply_unit
// Row vector times square matrix, accumulated column by column.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side is ready; a stalled result
// holds the whole pipe. A load beat writes the vector memory and gives no
// result; a matrix beat gives one result beat: the vector memory is read
// at the accepting edge, the multiply and the column sum memory read
// follow in stage 1, and the add and write-back into the output register
// in stage 2.
// The column sum memory is read, updated and written back once per beat; a
// result written in one cycle is forwarded to a beat of the same column that
// follows directly. Both memories start undefined: load each vector element
// before use and send row 0 of a column before its other rows. There is no
// clearing pass after reset. Write the length only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_matrix_multiply_unit #(
  parameter int MAX_LENGTH = vmm_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  vmm_in_if.sink                            in_chan,
  vmm_out_if.source                         out_chan,
  input  wire logic                         cfg_we,
  input  wire logic [vmm_pkg::LEN_W-1:0]    cfg_wdata
);

  localparam int AW        = $clog2(MAX_LENGTH);
  localparam int CW        = vmm_pkg::cmp_width(MAX_LENGTH);
  localparam int DW        = vmm_pkg::DATA_W;
  localparam int IW        = vmm_pkg::IDX_W;
  localparam int RCP_SH    = IW + AW;
  localparam int PW        = 2 * IW + 1;
  localparam logic [PW-1:0] RCP_M =
    PW'(((64'd1 << RCP_SH) + 64'(MAX_LENGTH) - 64'd1) / 64'(MAX_LENGTH));
  localparam logic [IW-1:0] LEN_LO = IW'(MAX_LENGTH);

  // input index to memory address, wrapping at the memory depth
  function automatic logic [AW-1:0] wrap_idx(input logic [IW-1:0] idx);
    logic [PW-1:0] prod_w;
    logic [IW-1:0] quo;
    logic [IW-1:0] rem;
    prod_w = PW'(idx) * RCP_M;
    quo    = IW'(prod_w >> RCP_SH);
    rem    = idx - IW'(quo * LEN_LO);
    return AW'(rem);
  endfunction

  logic [CW-1:0] last_row;

  vmm_cfg #(.MAX_LENGTH(MAX_LENGTH)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .last_row (last_row)
  );

  // handshake and stage advance
  logic in_fire;
  logic s1_adv;
  logic s2_adv;
  logic out_adv;

  logic          s1_valid_r;
  logic [AW-1:0] s1_ri_r;
  logic [AW-1:0] s1_ci_r;
  logic [IW-1:0] s1_col_r;
  logic [DW-1:0] s1_val_r;
  logic          s1_first_r;
  logic          s1_last_r;

  logic          s2_valid_r;
  logic [AW-1:0] s2_ci_r;
  logic [IW-1:0] s2_col_r;
  logic [DW-1:0] s2_prod_r;
  logic          s2_first_r;
  logic          s2_last_r;

  logic          out_valid_r;
  logic [IW-1:0] out_col_r;
  logic [DW-1:0] out_sum_r;
  logic          out_final_r;

  logic          fwd_valid_r;
  logic [AW-1:0] fwd_ci_r;
  logic [DW-1:0] fwd_sum_r;

  vmm_pkg::in_item_t in_item;
  logic [AW-1:0]     in_ri;
  logic [AW-1:0]     in_ci;
  logic              in_is_matrix;

  logic [DW-1:0] vec_rd;
  logic [AW-1:0] vec_rd_addr;
  logic          vec_we;
  logic [DW-1:0] sum_rd;
  logic [AW-1:0] sum_rd_addr;
  logic          sum_we;
  logic [DW-1:0] prod;
  logic [DW-1:0] base;
  logic [DW-1:0] acc;

  assign in_item      = in_chan.data;
  assign in_ri        = wrap_idx(in_item.row);
  assign in_ci        = wrap_idx(in_item.column);
  assign in_is_matrix = (in_item.operation == vmm_pkg::OP_MATRIX);

  assign out_adv = !out_valid_r || out_chan.ready;
  assign s2_adv  = !s2_valid_r || out_adv;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign in_chan.ready = s1_adv;
  assign in_fire = in_chan.valid && s1_adv;

  // vector memory: load beats write, matrix beats read
  assign vec_we      = in_fire && (in_item.operation == vmm_pkg::OP_LOAD);
  assign vec_rd_addr = s1_adv ? in_ri : s1_ri_r;

  vmm_ram #(.WIDTH(DW), .DEPTH(MAX_LENGTH)) u_vec_ram (
    .clk    (clk),
    .we     (vec_we),
    .wr_addr(in_ri),
    .wr_data(in_item.value),
    .rd_addr(vec_rd_addr),
    .rd_data(vec_rd)
  );

  // column sum memory: read in stage 1, written back from stage 2
  assign sum_rd_addr = s2_adv ? s1_ci_r : s2_ci_r;
  assign sum_we      = out_adv && s2_valid_r;

  vmm_ram #(.WIDTH(DW), .DEPTH(MAX_LENGTH)) u_sum_ram (
    .clk    (clk),
    .we     (sum_we),
    .wr_addr(s2_ci_r),
    .wr_data(acc),
    .rd_addr(sum_rd_addr),
    .rd_data(sum_rd)
  );

  assign prod = DW'(vec_rd * s1_val_r);
  assign base = (fwd_valid_r && (fwd_ci_r == s2_ci_r)) ? fwd_sum_r : sum_rd;
  assign acc  = s2_first_r ? s2_prod_r : (base + s2_prod_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_fire && in_is_matrix;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
      fwd_valid_r <= sum_we;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ri_r    <= in_ri;
      s1_ci_r    <= in_ci;
      s1_col_r   <= in_item.column;
      s1_val_r   <= in_item.value;
      s1_first_r <= (in_item.row == '0);
      s1_last_r  <= (CW'(in_item.row) == last_row);
    end
    if (s2_adv) begin
      s2_ci_r    <= s1_ci_r;
      s2_col_r   <= s1_col_r;
      s2_prod_r  <= prod;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
    end
    if (out_adv) begin
      out_col_r   <= s2_col_r;
      out_sum_r   <= acc;
      out_final_r <= s2_last_r;
    end
    fwd_ci_r  <= s2_ci_r;
    fwd_sum_r <= acc;
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.data.result_column = out_col_r;
  assign out_chan.data.column_sum    = $signed(out_sum_r);
  assign out_chan.data.final_res     = out_final_r;

endmodule

`default_nettype wire
